// ===== hw/rtl/rqsr_pkg.sv =====
// ----------------------------------------------------------------------------
// rqsr_pkg
// shared types and codes for the ready queue select and remove block
// ----------------------------------------------------------------------------
package rqsr_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;

    localparam logic [2:0] REQ_PUSH_BACK  = 3'd0;
    localparam logic [2:0] REQ_PUSH_FRONT = 3'd1;
    localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [2:0] REQ_POP_BACK   = 3'd3;
    localparam logic [2:0] REQ_POP_MIN    = 3'd4;
    localparam logic [2:0] REQ_POP_MAX    = 3'd5;
    localparam logic [2:0] REQ_REMOVE_AT  = 3'd6;

    localparam logic [1:0] STAT_DONE  = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;
    localparam logic [1:0] STAT_INDEX = 2'd3;

    localparam logic [1:0] SEL_HOLD  = 2'd0;
    localparam logic [1:0] SEL_LEFT  = 2'd1;
    localparam logic [1:0] SEL_RIGHT = 2'd2;
    localparam logic [1:0] SEL_NEW   = 2'd3;

    typedef struct packed {
        logic [15:0] pid;
        logic [7:0]  priority_lvl;
        logic [7:0]  burst;
    } entry_t;

    typedef struct packed {
        logic       clear;
        logic       step;
        logic [2:0] mode;
    } scan_ctrl_t;

endpackage

// ===== hw/rtl/rqsr_cell.sv =====
// ----------------------------------------------------------------------------
// rqsr_cell
// one queue slot: holds an entry, or takes it from a neighbor or the request
// ----------------------------------------------------------------------------
module rqsr_cell
    import rqsr_pkg::*;
(
    input  logic       clk,
    input  logic [1:0] sel,
    input  entry_t     left_entry,
    input  entry_t     right_entry,
    input  entry_t     new_entry,
    output entry_t     entry
);

    entry_t entry_reg;
    entry_t entry_next;

    always_comb
    begin
        unique case (sel)
            SEL_LEFT:  entry_next = left_entry;
            SEL_RIGHT: entry_next = right_entry;
            SEL_NEW:   entry_next = new_entry;
            default:   entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ===== hw/rtl/rqsr_scan.sv =====
// ----------------------------------------------------------------------------
// rqsr_scan
// watches the head cell while the ring rotates and keeps the chosen entry
// ----------------------------------------------------------------------------
module rqsr_scan
    import rqsr_pkg::*;
#(
    parameter int IDX_W = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  scan_ctrl_t       ctrl,
    input  logic [IDX_W-1:0] pos,
    input  logic [IDX_W-1:0] target,
    input  entry_t           head,
    output entry_t           best_entry,
    output logic [IDX_W-1:0] best_pos
);

    logic             found_reg;
    logic             found_next;
    entry_t           best_entry_reg;
    entry_t           best_entry_next;
    logic [IDX_W-1:0] best_pos_reg;
    logic [IDX_W-1:0] best_pos_next;
    logic             take;

    always_comb
    begin
        case (ctrl.mode)
            REQ_POP_MIN: take = !found_reg || (head.burst < best_entry_reg.burst);
            REQ_POP_MAX: take = !found_reg ||
                                (head.priority_lvl > best_entry_reg.priority_lvl);
            default:     take = (pos == target);
        endcase
    end

    always_comb
    begin
        found_next      = found_reg;
        best_entry_next = best_entry_reg;
        best_pos_next   = best_pos_reg;
        if (ctrl.clear)
        begin
            found_next = 1'b0;
        end
        else if (ctrl.step && take)
        begin
            found_next      = 1'b1;
            best_entry_next = head;
            best_pos_next   = pos;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else
        begin
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_entry_reg <= best_entry_next;
        best_pos_reg   <= best_pos_next;
    end

    assign best_entry = best_entry_reg;
    assign best_pos   = best_pos_reg;

endmodule

// ===== hw/rtl/ready_queue_select_remove.sv =====
// ----------------------------------------------------------------------------
// ready_queue_select_remove
// ordered ready queue with push, pop, remove at position and min/max select
// ----------------------------------------------------------------------------
// The queue is a ring of QUEUE_DEPTH cells. A request is taken when start is
// high and busy is low, and gives exactly one result on the following
// cycles, shown for one cycle with done high. The receiver cannot hold a
// result off: it must take the result in the cycle done is high. Pushes,
// requests that fail (full, empty, bad index) and the unused request code
// show their result in the next cycle and busy stays low, so a new request
// may be given every cycle. A removal that goes ahead holds busy high while
// the ring rotates once fully past the scan unit at the head cell, which
// picks the entry, and then while the close state closes the gap; done
// follows in the cycle busy falls. Ties in the min and max scans go to the
// entry nearest the front.
// ----------------------------------------------------------------------------
module ready_queue_select_remove
    import rqsr_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  req_type,
    input  logic [15:0] new_pid,
    input  logic [7:0]  new_priority,
    input  logic [7:0]  new_burst_count,
    input  logic [3:0]  entry_index,
    output logic        done,
    output logic [15:0] out_pid,
    output logic [7:0]  out_priority,
    output logic [7:0]  out_burst_count,
    output logic [1:0]  status,
    output logic [4:0]  occupancy
);

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;
    localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(QUEUE_DEPTH - 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_CLOSE = 2'd2;

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [IDX_W-1:0] scan_pos_reg;
    logic [IDX_W-1:0] scan_pos_next;
    logic [2:0]       mode_reg;
    logic [2:0]       mode_next;
    logic [IDX_W-1:0] target_reg;
    logic [IDX_W-1:0] target_next;

    logic             done_reg;
    logic             done_next;
    entry_t           res_entry_reg;
    entry_t           res_entry_next;
    logic [1:0]       status_reg;
    logic [1:0]       status_next;
    logic [4:0]       occupancy_reg;
    logic [4:0]       occupancy_next;

    logic             accept;
    logic             is_push;
    logic             is_remove;
    logic             full;
    logic             empty;
    logic             idx_bad;
    logic             do_push_back;
    logic             do_push_front;
    logic             go_scan;
    logic             immediate;
    logic [1:0]       imm_status;
    logic [IDX_W-1:0] target_calc;

    entry_t           new_entry;
    entry_t           cell_q [QUEUE_DEPTH];
    logic [1:0]       cell_sel [QUEUE_DEPTH];
    scan_ctrl_t       scan_ctrl;
    entry_t           best_entry;
    logic [IDX_W-1:0] best_pos;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    assign is_push   = (req_type == REQ_PUSH_BACK) || (req_type == REQ_PUSH_FRONT);
    assign is_remove = (req_type == REQ_POP_FRONT) || (req_type == REQ_POP_BACK) ||
                       (req_type == REQ_POP_MIN) || (req_type == REQ_POP_MAX) ||
                       (req_type == REQ_REMOVE_AT);
    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign idx_bad   = (CMP_W'(entry_index) >= CMP_W'(count_reg));

    assign do_push_back  = accept && (req_type == REQ_PUSH_BACK) && !full;
    assign do_push_front = accept && (req_type == REQ_PUSH_FRONT) && !full;
    assign go_scan       = accept && is_remove && !empty &&
                           !((req_type == REQ_REMOVE_AT) && idx_bad);
    assign immediate     = accept && !go_scan;

    assign new_entry.pid          = new_pid;
    assign new_entry.priority_lvl = new_priority;
    assign new_entry.burst        = new_burst_count;

    always_comb
    begin
        if (is_push && full)
        begin
            imm_status = STAT_FULL;
        end
        else if (is_remove && empty)
        begin
            imm_status = STAT_EMPTY;
        end
        else if ((req_type == REQ_REMOVE_AT) && idx_bad)
        begin
            imm_status = STAT_INDEX;
        end
        else
        begin
            imm_status = STAT_DONE;
        end
    end

    always_comb
    begin
        case (req_type)
            REQ_POP_BACK:  target_calc = IDX_W'(count_reg - 1'b1);
            REQ_REMOVE_AT: target_calc = IDX_W'(entry_index);
            default:       target_calc = '0;
        endcase
    end

    // per-cell source select
    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            cell_sel[i] = SEL_HOLD;
            if (do_push_back && (CNT_W'(i) == count_reg))
            begin
                cell_sel[i] = SEL_NEW;
            end
            else if (do_push_front)
            begin
                cell_sel[i] = (i == 0) ? SEL_NEW : SEL_LEFT;
            end
            else if (state_reg == ST_SCAN)
            begin
                cell_sel[i] = SEL_RIGHT;
            end
            else if ((state_reg == ST_CLOSE) && (IDX_W'(i) >= best_pos))
            begin
                cell_sel[i] = SEL_RIGHT;
            end
        end
    end

    for (genvar g = 0; g < QUEUE_DEPTH; g++)
    begin : g_cell
        rqsr_cell u_cell (
            .clk         (clk),
            .sel         (cell_sel[g]),
            .left_entry  (cell_q[(g + QUEUE_DEPTH - 1) % QUEUE_DEPTH]),
            .right_entry (cell_q[(g + 1) % QUEUE_DEPTH]),
            .new_entry   (new_entry),
            .entry       (cell_q[g])
        );
    end

    assign scan_ctrl.clear = go_scan;
    assign scan_ctrl.step  = (state_reg == ST_SCAN) && (CNT_W'(scan_pos_reg) < count_reg);
    assign scan_ctrl.mode  = mode_reg;

    rqsr_scan #(
        .IDX_W (IDX_W)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (scan_ctrl),
        .pos        (scan_pos_reg),
        .target     (target_reg),
        .head       (cell_q[0]),
        .best_entry (best_entry),
        .best_pos   (best_pos)
    );

    always_comb
    begin
        state_next    = state_reg;
        scan_pos_next = scan_pos_reg;
        mode_next     = mode_reg;
        target_next   = target_reg;
        count_next    = count_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                scan_pos_next = '0;
                if (do_push_back || do_push_front)
                begin
                    count_next = count_reg + 1'b1;
                end
                if (go_scan)
                begin
                    state_next  = ST_SCAN;
                    mode_next   = req_type;
                    target_next = target_calc;
                end
            end
            ST_SCAN:
            begin
                scan_pos_next = scan_pos_reg + 1'b1;
                if (scan_pos_reg == LAST_POS)
                begin
                    state_next = ST_CLOSE;
                end
            end
            ST_CLOSE:
            begin
                count_next = count_reg - 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        done_next      = 1'b0;
        res_entry_next = res_entry_reg;
        status_next    = status_reg;
        occupancy_next = occupancy_reg;
        if (immediate)
        begin
            done_next      = 1'b1;
            res_entry_next = '0;
            status_next    = imm_status;
            occupancy_next = 5'(count_next);
        end
        else if (state_reg == ST_CLOSE)
        begin
            done_next      = 1'b1;
            res_entry_next = best_entry;
            status_next    = STAT_DONE;
            occupancy_next = 5'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            scan_pos_reg <= '0;
            mode_reg     <= REQ_PUSH_BACK;
            target_reg   <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            scan_pos_reg <= scan_pos_next;
            mode_reg     <= mode_next;
            target_reg   <= target_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_entry_reg <= res_entry_next;
        status_reg    <= status_next;
        occupancy_reg <= occupancy_next;
    end

    assign done            = done_reg;
    assign out_pid         = res_entry_reg.pid;
    assign out_priority    = res_entry_reg.priority_lvl;
    assign out_burst_count = res_entry_reg.burst;
    assign status          = status_reg;
    assign occupancy       = occupancy_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("fill count above queue depth");

    a_close_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLOSE) |=> (done && (status == STAT_DONE)))
        else $error("removal did not report its entry");

    a_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_push && full) |=> (done && (status == STAT_FULL) && $stable(count_reg)))
        else $error("push on full queue not rejected");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != STAT_DONE)) |-> (out_pid == '0))
        else $error("failed request returned an entry");
`endif

endmodule

// ===== tb/ready_queue_select_remove_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ready_queue_select_remove_test
// self-checking bench for the ready queue: directed corner requests, then
// random fill and drain traffic under several sender idle rates; every
// result is checked against a behavioral copy of the queue
// ----------------------------------------------------------------------------
module ready_queue_select_remove_test;
    import rqsr_pkg::*;

    localparam logic [2:0] REQ_UNUSED  = 3'd7;
    localparam int         STALL_LIMIT = 2000;

    typedef struct packed {
        logic [15:0] pid;
        logic [7:0]  priority_lvl;
        logic [7:0]  burst;
        logic [1:0]  status;
        logic [4:0]  occupancy;
    } request_result_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  req_type;
    logic [15:0] new_pid;
    logic [7:0]  new_priority;
    logic [7:0]  new_burst_count;
    logic [3:0]  entry_index;
    logic        done;
    logic [15:0] out_pid;
    logic [7:0]  out_priority;
    logic [7:0]  out_burst_count;
    logic [1:0]  status;
    logic [4:0]  occupancy;

    entry_t          queue_slots [QUEUE_DEPTH_DEF];
    int              queue_fill;
    request_result_t pending_results[$];
    int              error_count;
    int              stall_cycles;
    int              idle_pct;

    ready_queue_select_remove dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .req_type        (req_type),
        .new_pid         (new_pid),
        .new_priority    (new_priority),
        .new_burst_count (new_burst_count),
        .entry_index     (entry_index),
        .done            (done),
        .out_pid         (out_pid),
        .out_priority    (out_priority),
        .out_burst_count (out_burst_count),
        .status          (status),
        .occupancy       (occupancy)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic request_result_t apply_request(logic [2:0] req, logic [15:0] pid,
                                                      logic [7:0] prio, logic [7:0] burst,
                                                      logic [3:0] idx);
        request_result_t res;
        int              pick;
        res = '0;
        pick = -1;
        res.status = STAT_DONE;
        if (req == REQ_PUSH_BACK || req == REQ_PUSH_FRONT)
        begin
            if (queue_fill >= QUEUE_DEPTH_DEF)
                res.status = STAT_FULL;
            else if (req == REQ_PUSH_BACK)
            begin
                queue_slots[queue_fill] = {pid, prio, burst};
                queue_fill++;
            end
            else
            begin
                for (int i = queue_fill; i > 0; i--)
                    queue_slots[i] = queue_slots[i - 1];
                queue_slots[0] = {pid, prio, burst};
                queue_fill++;
            end
        end
        else if (req != REQ_UNUSED)
        begin
            if (queue_fill == 0)
                res.status = STAT_EMPTY;
            else
            begin
                case (req)
                    REQ_POP_FRONT: pick = 0;
                    REQ_POP_BACK:  pick = queue_fill - 1;
                    REQ_POP_MIN:
                    begin
                        pick = 0;
                        for (int i = 1; i < queue_fill; i++)
                            if (queue_slots[i].burst < queue_slots[pick].burst)
                                pick = i;
                    end
                    REQ_POP_MAX:
                    begin
                        pick = 0;
                        for (int i = 1; i < queue_fill; i++)
                            if (queue_slots[i].priority_lvl > queue_slots[pick].priority_lvl)
                                pick = i;
                    end
                    default:
                    begin
                        if (int'(idx) < queue_fill)
                            pick = int'(idx);
                        else
                            res.status = STAT_INDEX;
                    end
                endcase
                if (pick >= 0)
                begin
                    res.pid          = queue_slots[pick].pid;
                    res.priority_lvl = queue_slots[pick].priority_lvl;
                    res.burst        = queue_slots[pick].burst;
                    for (int i = pick; i < queue_fill - 1; i++)
                        queue_slots[i] = queue_slots[i + 1];
                    queue_fill--;
                end
            end
        end
        res.occupancy = 5'(queue_fill);
        return res;
    endfunction

    // drives one request and waits for it to be taken; start stays high
    task automatic send_request(logic [2:0] req, logic [15:0] pid, logic [7:0] prio,
                                logic [7:0] burst, logic [3:0] idx);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
        start           <= 1'b1;
        req_type        <= req;
        new_pid         <= pid;
        new_priority    <= prio;
        new_burst_count <= burst;
        entry_index     <= idx;
        do
            @(posedge clk);
        while (busy);
        pending_results.push_back(apply_request(req, pid, prio, burst, idx));
    endtask

    task automatic wait_for_drain();
        start <= 1'b0;
        while (pending_results.size() > 0)
            @(posedge clk);
    endtask

    task automatic test_empty_requests();
        send_request(REQ_POP_FRONT, 16'h0000, 8'h00, 8'h00, 4'd0);
        send_request(REQ_POP_BACK, 16'h0000, 8'h00, 8'h00, 4'd0);
        send_request(REQ_POP_MIN, 16'h0000, 8'h00, 8'h00, 4'd0);
        send_request(REQ_POP_MAX, 16'h0000, 8'h00, 8'h00, 4'd0);
        send_request(REQ_REMOVE_AT, 16'h0000, 8'h00, 8'h00, 4'd0);
        send_request(REQ_UNUSED, 16'hffff, 8'hff, 8'hff, 4'hf);
    endtask

    task automatic test_push_extremes();
        send_request(REQ_PUSH_BACK, 16'hffff, 8'h00, 8'hff, 4'd0);
        send_request(REQ_PUSH_FRONT, 16'h0000, 8'hff, 8'h00, 4'hf);
        send_request(REQ_PUSH_BACK, 16'h1234, 8'hff, 8'h00, 4'd0);
        send_request(REQ_PUSH_BACK, 16'h0005, 8'h7f, 8'h80, 4'd0);
        send_request(REQ_UNUSED, 16'hffff, 8'hff, 8'hff, 4'hf);
    endtask

    task automatic test_remove_at_bounds();
        send_request(REQ_REMOVE_AT, 16'h0000, 8'h00, 8'h00, 4'hf);
        send_request(REQ_REMOVE_AT, 16'h0000, 8'h00, 8'h00, 4'd4);
    endtask

    // front entry wins equal burst and equal priority
    task automatic test_scan_ties();
        send_request(REQ_POP_MIN, 16'h0000, 8'h00, 8'h00, 4'd0);
        send_request(REQ_PUSH_FRONT, 16'h0021, 8'hff, 8'h40, 4'd0);
        send_request(REQ_POP_MAX, 16'h0000, 8'h00, 8'h00, 4'd0);
        send_request(REQ_REMOVE_AT, 16'h0000, 8'h00, 8'h00, 4'd1);
        send_request(REQ_POP_BACK, 16'h0000, 8'h00, 8'h00, 4'd0);
        send_request(REQ_PUSH_FRONT, 16'haaaa, 8'h55, 8'haa, 4'd0);
        send_request(REQ_POP_FRONT, 16'h0000, 8'h00, 8'h00, 4'd0);
    endtask

    // winner sits in the last slot
    task automatic test_scan_last_entry();
        send_request(REQ_PUSH_BACK, 16'h0011, 8'd1, 8'd9, 4'd0);
        send_request(REQ_PUSH_BACK, 16'h0012, 8'd2, 8'd8, 4'd0);
        send_request(REQ_PUSH_BACK, 16'h0013, 8'd200, 8'd1, 4'd0);
        send_request(REQ_POP_MIN, 16'h0000, 8'h00, 8'h00, 4'd0);
        send_request(REQ_PUSH_BACK, 16'h0014, 8'd250, 8'd5, 4'd0);
        send_request(REQ_POP_MAX, 16'h0000, 8'h00, 8'h00, 4'd0);
    endtask

    function automatic logic [7:0] pick_field();
        if ($urandom_range(1) == 0)
            return 8'($urandom_range(3));
        return 8'($urandom_range(255));
    endfunction

    // alternate fill and drain runs so full and empty are both reached often
    task automatic test_random_traffic(int pct, int item_total);
        logic [2:0] req;
        logic [3:0] idx;
        int         roll;
        bit         filling;
        idle_pct = pct;
        filling = 1'b1;
        for (int n = 0; n < item_total; n++)
        begin
            if (filling && queue_fill == QUEUE_DEPTH_DEF && $urandom_range(3) == 0)
                filling = 1'b0;
            else if (!filling && queue_fill == 0 && $urandom_range(3) == 0)
                filling = 1'b1;
            roll = $urandom_range(99);
            if (roll < 3)
                req = REQ_UNUSED;
            else if (roll < 8)
                req = 3'($urandom_range(6));
            else if ((roll < 80) == filling)
                req = $urandom_range(1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
            else
                req = 3'($urandom_range(REQ_REMOVE_AT, REQ_POP_FRONT));
            if (queue_fill > 0 && $urandom_range(9) < 7)
                idx = 4'($urandom_range(queue_fill - 1));
            else
                idx = 4'($urandom_range(15));
            send_request(req, 16'($urandom), pick_field(), pick_field(), idx);
        end
        wait_for_drain();
    endtask

    always @(posedge clk)
    begin
        request_result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no request waiting: pid %h status %0d", out_pid, status);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_pid !== want.pid)
                begin
                    $error("out_pid expected %h actual %h", want.pid, out_pid);
                    error_count++;
                end
                if (out_priority !== want.priority_lvl)
                begin
                    $error("out_priority expected %h actual %h", want.priority_lvl, out_priority);
                    error_count++;
                end
                if (out_burst_count !== want.burst)
                begin
                    $error("out_burst_count expected %h actual %h", want.burst, out_burst_count);
                    error_count++;
                end
                if (status !== want.status)
                begin
                    $error("status expected %0d actual %0d", want.status, status);
                    error_count++;
                end
                if (occupancy !== want.occupancy)
                begin
                    $error("occupancy expected %0d actual %0d", want.occupancy, occupancy);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("ready_queue_select_remove verification failed");
            $finish;
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        start           = 1'b0;
        req_type        = REQ_PUSH_BACK;
        new_pid         = '0;
        new_priority    = '0;
        new_burst_count = '0;
        entry_index     = '0;
        queue_fill      = 0;
        error_count     = 0;
        stall_cycles    = 0;
        idle_pct        = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_requests();
        test_push_extremes();
        test_remove_at_bounds();
        test_scan_ties();
        test_scan_last_entry();
        wait_for_drain();

        test_random_traffic(0, 282);
        test_random_traffic(64, 282);
        test_random_traffic(0, 282);
        test_random_traffic(9, 282);

        repeat (QUEUE_DEPTH_DEF + 4) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("ready_queue_select_remove verification clean");
        else
            $display("ready_queue_select_remove verification failed");
        $finish;
    end

endmodule
